// ===== rtl/pmsm_field_oriented_current_speed_ctrl_unit_assert.svh =====
// Assertion macros used by the field-oriented controller sequencer.
// Needs a clock and an active-low reset name at each use.
`ifndef PMSM_FIELD_ORIENTED_CURRENT_SPEED_CTRL_UNIT_ASSERT_SVH
`define PMSM_FIELD_ORIENTED_CURRENT_SPEED_CTRL_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFOC_ASSERT_NOW(name, clk_s, rst_n, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pfoc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PFOC_ASSERT_NEXT(name, clk_s, rst_n, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pfoc assertion failed");

`endif

// ===== rtl/pfoc_pkg.sv =====
// Shared types and constants of the field-oriented controller.
// Used by the controller, the datapath and the top level.
package pfoc_pkg;

	// sequencer steps, one per clock outside the IDLE and DONE waits
	typedef enum logic [5:0] {
		ST_IDLE,
		ST_SX,
		ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8,
		ST_P1, ST_P2, ST_P3, ST_P4, ST_P5,
		ST_V1, ST_V2,
		ST_W1, ST_W2, ST_W3,
		ST_PI1, ST_PI2, ST_PI3, ST_PI4, ST_PI5, ST_PI6, ST_PI7,
		ST_DE, ST_QE,
		ST_I1, ST_I2, ST_I3, ST_I4, ST_I5,
		ST_DONE
	} step_t;

	typedef enum logic [1:0] {
		LP_SPD,
		LP_D,
		LP_Q
	} loop_t;

	typedef struct packed {
		step_t step;
		loop_t lp;
		logic  cos_pass;
		logic  take;
		logic  publish;
	} dp_cmd_t;

	typedef struct packed {
		logic [15:0]        kp_cur;
		logic [15:0]        ki_cur;
		logic [15:0]        kp_spd;
		logic [15:0]        ki_spd;
		logic [14:0]        iq_lim;
		logic [15:0]        spd_scale;
		logic signed [15:0] align_cur;
	} cfg_t;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_KP_CURRENT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KI_CURRENT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KP_SPEED    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KI_SPEED    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_IQ_LIMIT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_CUR   = 3'd6;

	// 0.57735 in Q0.16
	localparam int unsigned VS_COEF = 37837;

	// quarter-wave sine polynomial, Q16
	localparam int unsigned SIN_C1 = 102919;
	localparam int unsigned SIN_C3 = 42121;
	localparam int unsigned SIN_C5 = 4739;

endpackage

// ===== rtl/pfoc_datapath.sv =====
// Datapath of the field-oriented controller: shared multiplier, sine unit,
// Park transforms and the three PI loops. Depends on pfoc_pkg.
module pfoc_datapath import pfoc_pkg::*; #(
	parameter int DATA_BITS        = 16,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dp_cmd_t                     cmd,
	input  cfg_t                        cfg,
	input  logic signed [DATA_BITS-1:0] i_alpha,
	input  logic signed [DATA_BITS-1:0] i_beta,
	input  logic [15:0]                 rotor_angle,
	input  logic signed [DATA_BITS-1:0] rotor_speed,
	input  logic signed [DATA_BITS-1:0] speed_reference,
	input  logic [DATA_BITS-1:0]        bus_voltage,
	input  logic                        align,
	output logic                        align_mode,
	output logic signed [DATA_BITS-1:0] v_alpha,
	output logic signed [DATA_BITS-1:0] v_beta,
	output logic signed [DATA_BITS-1:0] i_d,
	output logic signed [DATA_BITS-1:0] i_q,
	output logic signed [DATA_BITS-1:0] iq_command,
	output logic                        d_limited,
	output logic                        q_limited
);

	localparam int DB  = DATA_BITS;
	localparam int OW  = (DB + 2 > 20) ? DB + 2 : 20;
	localparam int PW  = 2 * OW;
	localparam int SW  = PW + 1;
	localparam int EW  = ((DB > 16) ? DB : 16) + 1;
	localparam int PSW = EW + 9;
	localparam int UW  = EW + 10;
	localparam int LW  = DB + 1;
	localparam int VW  = DB + 2;
	localparam int XW  = 48;
	localparam int TSH = 16 - $clog2(SINE_TABLE_DEPTH);
	localparam logic [15:0] ANG_MASK = ~((16'd1 << TSH) - 16'd1);
	localparam logic signed [SW-1:0] DMAX_W = SW'((64'sd1 <<< (DB - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] DMIN_W = -DMAX_W - SW'(1);
	localparam logic signed [PW-1:0] AMP_P  = PW'((64'sd1 <<< (DB - 1)) - 64'sd1);
	localparam logic signed [XW-1:0] S32MAX = XW'(64'sd2147483647);
	localparam logic signed [XW-1:0] S32MIN = -S32MAX - XW'(1);
	localparam logic signed [XW-1:0] S18MAX = XW'(64'sd131071);
	localparam logic signed [XW-1:0] S18MIN = -S18MAX - XW'(1);

	function automatic logic signed [DB-1:0] sat_db(input logic signed [SW-1:0] v);
		logic signed [DB-1:0] r;
		if (v > DMAX_W)
			r = DMAX_W[DB-1:0];
		else if (v < DMIN_W)
			r = DMIN_W[DB-1:0];
		else
			r = v[DB-1:0];
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [XW-1:0] v);
		logic signed [31:0] r;
		if (v > S32MAX)
			r = S32MAX[31:0];
		else if (v < S32MIN)
			r = S32MIN[31:0];
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [17:0] sat18(input logic signed [XW-1:0] v);
		logic signed [17:0] r;
		if (v > S18MAX)
			r = S18MAX[17:0];
		else if (v < S18MIN)
			r = S18MIN[17:0];
		else
			r = v[17:0];
		return r;
	endfunction

	// captured item
	logic signed [DB-1:0] ia_q, ib_q, wr_q, sref_q;
	logic [DB-1:0]        bus_q;
	logic                 align_q;
	logic [15:0]          ang_q;

	// sine unit
	logic [1:0]           quad_q;
	logic [16:0]          x_q, x2_q, t_q;
	logic signed [DB-1:0] sin_q, cos_q;

	// shared multiplier
	logic signed [OW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod_q, acc_q;

	// transforms and loops
	logic signed [DB-1:0] id_q, iq_q, va_q, vb_q, wref_q;
	logic [DB-1:0]        vdmax_q;
	logic signed [EW-1:0] err_q;
	logic signed [17:0]   eki_q;
	logic signed [18:0]   esum_q;
	logic signed [PSW-1:0] p_q;
	logic signed [UW-1:0] u_q;
	logic                 hi_q, lo_q;
	logic signed [15:0]   iqref_q;
	logic signed [VW-1:0] vd_q, vq_q;
	logic                 dl_q, ql_q;

	logic signed [31:0]   integ_q [3];
	logic signed [17:0]   prev_q  [3];
	logic signed [31:0]   wind_q  [3];

	// result register
	logic signed [DB-1:0] o_va_q, o_vb_q, o_id_q, o_iq_q, o_iqc_q;
	logic                 o_dl_q, o_ql_q;

	// sine helpers
	logic [15:0]          ph;
	logic [16:0]          x_raw;
	logic signed [PW-1:0] rnd;
	logic signed [DB-1:0] sine_mag, sine_val;

	// loop selection
	logic [15:0]          kp_sel, ki_sel;
	logic [LW-1:0]        lim_sel;
	logic signed [UW-1:0] lim_s, out_v;
	logic signed [31:0]   integ_cur, wind_cur;
	logic signed [17:0]   prev_cur;
	logic signed [EW-1:0] id_ref;

	always_comb begin
		ph    = cmd.cos_pass ? ang_q + 16'd16384 : ang_q;
		x_raw = {1'b0, ph[13:0], 2'b00};
		rnd   = (prod_q + PW'(32768)) >>> 16;
		if (rnd > AMP_P)
			sine_mag = AMP_P[DB-1:0];
		else
			sine_mag = rnd[DB-1:0];
		sine_val = quad_q[1] ? -sine_mag : sine_mag;
	end

	always_comb begin
		case (cmd.lp)
			LP_SPD: begin
				kp_sel  = cfg.kp_spd;
				ki_sel  = cfg.ki_spd;
				lim_sel = LW'(cfg.iq_lim);
			end
			LP_D: begin
				kp_sel  = cfg.kp_cur;
				ki_sel  = cfg.ki_cur;
				lim_sel = {1'b0, vdmax_q};
			end
			default: begin
				kp_sel  = cfg.kp_cur;
				ki_sel  = cfg.ki_cur;
				lim_sel = {vdmax_q, 1'b0};
			end
		endcase
		lim_s     = UW'($signed({1'b0, lim_sel}));
		integ_cur = integ_q[cmd.lp];
		prev_cur  = prev_q[cmd.lp];
		wind_cur  = wind_q[cmd.lp];
		if (hi_q)
			out_v = lim_s;
		else if (lo_q)
			out_v = -lim_s;
		else
			out_v = u_q;
		id_ref = align_q ? EW'(cfg.align_cur) : '0;
	end

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.step)
			ST_M1: begin
				mul_a = OW'($signed({1'b0, x_q}));
				mul_b = OW'($signed({1'b0, x_q}));
			end
			ST_M2: begin
				mul_a = OW'($signed({1'b0, 17'(SIN_C5)}));
				mul_b = OW'($signed({1'b0, prod_q[32:16]}));
			end
			ST_M4: begin
				mul_a = OW'($signed({1'b0, t_q}));
				mul_b = OW'($signed({1'b0, x2_q}));
			end
			ST_M6: begin
				mul_a = OW'($signed({1'b0, t_q}));
				mul_b = OW'($signed({1'b0, x_q}));
			end
			ST_M7: begin
				mul_a = OW'($signed({1'b0, prod_q[32:16]}));
				mul_b = OW'(AMP_P);
			end
			ST_P1: begin
				mul_a = OW'(cos_q);
				mul_b = OW'(ia_q);
			end
			ST_P2: begin
				mul_a = OW'(sin_q);
				mul_b = OW'(ib_q);
			end
			ST_P3: begin
				mul_a = OW'(cos_q);
				mul_b = OW'(ib_q);
			end
			ST_P4: begin
				mul_a = OW'(sin_q);
				mul_b = OW'(ia_q);
			end
			ST_V1: begin
				mul_a = OW'($signed({1'b0, 16'(VS_COEF)}));
				mul_b = OW'($signed({1'b0, bus_q}));
			end
			ST_W1: begin
				mul_a = OW'($signed({1'b0, cfg.spd_scale}));
				mul_b = OW'(sref_q);
			end
			ST_PI1: begin
				mul_a = OW'($signed({1'b0, kp_sel}));
				mul_b = OW'(err_q);
			end
			ST_PI3: begin
				mul_a = OW'($signed({1'b0, ki_sel}));
				mul_b = OW'(esum_q);
			end
			ST_I1: begin
				mul_a = OW'(cos_q);
				mul_b = OW'(vd_q);
			end
			ST_I2: begin
				mul_a = OW'(sin_q);
				mul_b = OW'(vq_q);
			end
			ST_I3: begin
				mul_a = OW'(sin_q);
				mul_b = OW'(vd_q);
			end
			ST_I4: begin
				mul_a = OW'(cos_q);
				mul_b = OW'(vq_q);
			end
			default: ;
		endcase
	end

	// working registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.take) begin
			ia_q    <= i_alpha;
			ib_q    <= i_beta;
			wr_q    <= rotor_speed;
			sref_q  <= speed_reference;
			bus_q   <= bus_voltage;
			align_q <= align;
			ang_q   <= align ? 16'd0 : (rotor_angle & ANG_MASK);
			iqref_q <= '0;
		end
		case (cmd.step)
			ST_SX: begin
				quad_q <= ph[15:14];
				x_q    <= ph[14] ? 17'h10000 - x_raw : x_raw;
			end
			ST_M2: x2_q <= prod_q[32:16];
			ST_M3: t_q  <= 17'(SIN_C3) - prod_q[32:16];
			ST_M5: t_q  <= 17'(SIN_C1) - prod_q[32:16];
			ST_M8: begin
				if (cmd.cos_pass)
					cos_q <= sine_val;
				else
					sin_q <= sine_val;
			end
			ST_P2, ST_P4, ST_I2, ST_I4: acc_q <= prod_q;
			ST_P3: id_q <= sat_db((SW'(acc_q) + SW'(prod_q)) >>> (DB - 1));
			ST_P5: iq_q <= sat_db((SW'(acc_q) - SW'(prod_q)) >>> (DB - 1));
			ST_V2: vdmax_q <= prod_q[16 +: DB];
			ST_W2: wref_q <= sat_db(SW'(prod_q >>> 8));
			ST_W3: err_q <= EW'(wref_q) - EW'(wr_q);
			ST_DE: err_q <= id_ref - EW'(id_q);
			ST_QE: err_q <= EW'(iqref_q) - EW'(iq_q);
			ST_PI1: eki_q <= sat18(XW'(err_q) - XW'(wind_cur));
			ST_PI2: begin
				p_q    <= PSW'(prod_q >>> 8);
				esum_q <= 19'(eki_q) + 19'(prev_cur);
			end
			ST_PI5: u_q <= UW'(p_q) + UW'(integ_cur >>> 16);
			ST_PI6: begin
				hi_q <= (u_q >= lim_s);
				lo_q <= (u_q <= -lim_s);
			end
			ST_PI7: begin
				case (cmd.lp)
					LP_SPD: iqref_q <= 16'(out_v);
					LP_D: begin
						vd_q <= VW'(out_v);
						dl_q <= hi_q | lo_q;
					end
					default: begin
						vq_q <= VW'(out_v);
						ql_q <= hi_q | lo_q;
					end
				endcase
			end
			ST_I3: va_q <= sat_db((SW'(acc_q) - SW'(prod_q)) >>> (DB - 1));
			ST_I5: vb_q <= sat_db((SW'(acc_q) + SW'(prod_q)) >>> (DB - 1));
			default: ;
		endcase
		if (cmd.publish) begin
			o_va_q  <= va_q;
			o_vb_q  <= vb_q;
			o_id_q  <= id_q;
			o_iq_q  <= iq_q;
			o_iqc_q <= DB'(iqref_q);
			o_dl_q  <= dl_q;
			o_ql_q  <= ql_q;
		end
	end

	// loop state, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				integ_q[i] <= '0;
				prev_q[i]  <= '0;
				wind_q[i]  <= '0;
			end
		end else begin
			if (cmd.step == ST_PI4)
				integ_q[cmd.lp] <= sat32(XW'(integ_cur) + XW'(prod_q));
			if (cmd.step == ST_PI7) begin
				wind_q[cmd.lp] <= sat32(XW'(u_q) - XW'(out_v));
				prev_q[cmd.lp] <= eki_q;
			end
		end
	end

	assign align_mode = align_q;
	assign v_alpha    = o_va_q;
	assign v_beta     = o_vb_q;
	assign i_d        = o_id_q;
	assign i_q        = o_iq_q;
	assign iq_command = o_iqc_q;
	assign d_limited  = o_dl_q;
	assign q_limited  = o_ql_q;

endmodule

// ===== rtl/pfoc_ctrl.sv =====
// Sequencer of the field-oriented controller: steps the datapath through
// one control tick and owns the input and output handshakes. Uses pfoc_pkg.
`include "pmsm_field_oriented_current_speed_ctrl_unit_assert.svh"

module pfoc_ctrl import pfoc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	input  logic    align_mode,
	output dp_cmd_t cmd
);

	step_t state_q, state_d;
	loop_t lp_q, lp_d;
	logic  cos_q, cos_d;
	logic  out_valid_q;
	logic  go;

	assign go = !out_valid_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		lp_d    = lp_q;
		cos_d   = cos_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_SX;
					cos_d   = 1'b0;
				end
			end
			ST_SX:  state_d = ST_M1;
			ST_M1:  state_d = ST_M2;
			ST_M2:  state_d = ST_M3;
			ST_M3:  state_d = ST_M4;
			ST_M4:  state_d = ST_M5;
			ST_M5:  state_d = ST_M6;
			ST_M6:  state_d = ST_M7;
			ST_M7:  state_d = ST_M8;
			ST_M8: begin
				if (cos_q) begin
					state_d = ST_P1;
				end else begin
					state_d = ST_SX;
					cos_d   = 1'b1;
				end
			end
			ST_P1:  state_d = ST_P2;
			ST_P2:  state_d = ST_P3;
			ST_P3:  state_d = ST_P4;
			ST_P4:  state_d = ST_P5;
			ST_P5:  state_d = ST_V1;
			ST_V1:  state_d = ST_V2;
			ST_V2:  state_d = align_mode ? ST_DE : ST_W1;
			ST_W1:  state_d = ST_W2;
			ST_W2:  state_d = ST_W3;
			ST_W3: begin
				state_d = ST_PI1;
				lp_d    = LP_SPD;
			end
			ST_PI1: state_d = ST_PI2;
			ST_PI2: state_d = ST_PI3;
			ST_PI3: state_d = ST_PI4;
			ST_PI4: state_d = ST_PI5;
			ST_PI5: state_d = ST_PI6;
			ST_PI6: state_d = ST_PI7;
			ST_PI7: begin
				unique case (lp_q)
					LP_SPD:  state_d = ST_DE;
					LP_D:    state_d = ST_QE;
					default: state_d = ST_I1;
				endcase
			end
			ST_DE: begin
				state_d = ST_PI1;
				lp_d    = LP_D;
			end
			ST_QE: begin
				state_d = ST_PI1;
				lp_d    = LP_Q;
			end
			ST_I1:  state_d = ST_I2;
			ST_I2:  state_d = ST_I3;
			ST_I3:  state_d = ST_I4;
			ST_I4:  state_d = ST_I5;
			ST_I5:  state_d = ST_DONE;
			ST_DONE: begin
				if (go)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready     = (state_q == ST_IDLE);
		cmd.step     = state_q;
		cmd.lp       = lp_q;
		cmd.cos_pass = cos_q;
		cmd.take     = (state_q == ST_IDLE) && s_tvalid;
		cmd.publish  = (state_q == ST_DONE) && go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lp_q        <= LP_SPD;
			cos_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			lp_q    <= lp_d;
			cos_q   <= cos_d;
			if (cmd.publish)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

	`PFOC_ASSERT_NEXT(a_accept_starts_sine, clk, arst_n, s_tvalid && s_tready, state_q == ST_SX && !cos_q)
	`PFOC_ASSERT_NEXT(a_cos_pass_follows, clk, arst_n, state_q == ST_M8 && !cos_q, state_q == ST_SX && cos_q)
	`PFOC_ASSERT_NEXT(a_result_held, clk, arst_n, out_valid_q && !m_tready, out_valid_q)
	`PFOC_ASSERT_NEXT(a_q_loop_to_inv, clk, arst_n, state_q == ST_PI7 && lp_q == LP_Q, state_q == ST_I1)

endmodule

// ===== rtl/pmsm_field_oriented_current_speed_ctrl_unit.sv =====
// Items are handled one at a time: a new item is accepted only in the idle state.
// In align mode the speed scaling and speed loop steps are skipped. One shared multiplier
// carries every product: sine/cosine, Park, voltage limit, speed scaling, speed, d and q loops,
// inverse Park. A new item is taken while the previous result waits in the output register.
// Reset (arst_n low, asynchronous) clears the sequencer, loop integrators,
// windup and error history, and loads the configuration defaults.
module pmsm_field_oriented_current_speed_ctrl_unit import pfoc_pkg::*; #(
	parameter int DATA_BITS        = 16,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// i_alpha, i_beta, rotor_angle[15:0], rotor_speed, speed_reference,
	// bus_voltage, then zero fill
	input  logic [((5*DATA_BITS+16+7)/8)*8-1:0] s_tdata,
	// align
	input  logic                                s_tuser,
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// v_alpha, v_beta, i_d, i_q, iq_command, then zero fill
	output logic [((5*DATA_BITS+7)/8)*8-1:0]    m_tdata,
	// d_limited, q_limited
	output logic [1:0]                          m_tuser,
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [CFG_IDX_W-1:0]                cfg_index,
	input  logic [15:0]                         cfg_data
);

	localparam int DB    = DATA_BITS;
	localparam int OUT_W = ((5 * DB + 7) / 8) * 8;

	cfg_t    cfg_q;
	dp_cmd_t cmd;
	logic    align_mode;

	logic signed [DB-1:0] v_alpha, v_beta, i_d, i_q, iq_command;
	logic                 d_limited, q_limited;

	// register file; writes land any cycle, the block only needs them stable per tick
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_cur    <= 16'd256;
			cfg_q.ki_cur    <= 16'd0;
			cfg_q.kp_spd    <= 16'd256;
			cfg_q.ki_spd    <= 16'd0;
			cfg_q.iq_lim    <= 15'd16384;
			cfg_q.spd_scale <= 16'd256;
			cfg_q.align_cur <= -16'sd16384;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_KP_CURRENT:  cfg_q.kp_cur    <= cfg_data;
				CFG_KI_CURRENT:  cfg_q.ki_cur    <= cfg_data;
				CFG_KP_SPEED:    cfg_q.kp_spd    <= cfg_data;
				CFG_KI_SPEED:    cfg_q.ki_spd    <= cfg_data;
				CFG_IQ_LIMIT:    cfg_q.iq_lim    <= cfg_data[14:0];
				CFG_SPEED_SCALE: cfg_q.spd_scale <= cfg_data;
				CFG_ALIGN_CUR:   cfg_q.align_cur <= $signed(cfg_data);
				default: ;  // index past the register list is dropped
			endcase
		end
	end

	// sequencer: handshakes and step order
	pfoc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.align_mode (align_mode),
		.cmd        (cmd)
	);

	// arithmetic, loop state and the result register
	pfoc_datapath #(
		.DATA_BITS        (DATA_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg             (cfg_q),
		.i_alpha         ($signed(s_tdata[0 +: DB])),
		.i_beta          ($signed(s_tdata[DB +: DB])),
		.rotor_angle     (s_tdata[2*DB +: 16]),
		.rotor_speed     ($signed(s_tdata[2*DB+16 +: DB])),
		.speed_reference ($signed(s_tdata[3*DB+16 +: DB])),
		.bus_voltage     (s_tdata[4*DB+16 +: DB]),
		.align           (s_tuser),
		.align_mode      (align_mode),
		.v_alpha         (v_alpha),
		.v_beta          (v_beta),
		.i_d             (i_d),
		.i_q             (i_q),
		.iq_command      (iq_command),
		.d_limited       (d_limited),
		.q_limited       (q_limited)
	);

	assign m_tdata = OUT_W'({iq_command, i_q, i_d, v_beta, v_alpha});
	assign m_tuser = {q_limited, d_limited};

endmodule

// ===== test/pmsm_field_oriented_current_speed_ctrl_unit_test.sv =====
// Testbench of the field-oriented speed/current controller: random and directed ticks,
// a fixed-point predictor of the three PI loops and Park transforms, result checking.
// Depends on pfoc_pkg and the top level pmsm_field_oriented_current_speed_ctrl_unit.

typedef struct packed {
	logic signed [15:0] v_alpha, v_beta, i_d, i_q, iq_cmd;
	logic               d_lim, q_lim;
} foc_result_t;

class foc_scoreboard;
	foc_result_t pending[$];
	int          mismatches;

	function void note_input(foc_result_t r);
		pending.push_back(r);
	endfunction

	function void check_result(foc_result_t got);
		foc_result_t want;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result transfer");
			return;
		end
		want = pending.pop_front();
		if (got != want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp va=%0d vb=%0d id=%0d iq=%0d iqc=%0d dl=%0b ql=%0b",
					want.v_alpha, want.v_beta, want.i_d, want.i_q, want.iq_cmd,
					want.d_lim, want.q_lim,
					"\n          got va=%0d vb=%0d id=%0d iq=%0d iqc=%0d dl=%0b ql=%0b",
					got.v_alpha, got.v_beta, got.i_d, got.i_q, got.iq_cmd,
					got.d_lim, got.q_lim);
		end
	endfunction
endclass

module pmsm_field_oriented_current_speed_ctrl_unit_test;
	import pfoc_pkg::*;

	localparam int WATCHDOG = 20000;
	localparam int DEPTH    = 1024;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	pmsm_field_oriented_current_speed_ctrl_unit u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state: integral, previous error, windup excess per loop
	longint      integ[3], prev_err[3], windup[3];
	longint      kp_cur, ki_cur, kp_spd, ki_spd, iq_lim, spd_scale, align_cur;
	foc_scoreboard board = new();
	bit          quiet_sender, quiet_sink;
	int          idle_cycles = 0;

	function automatic longint sat(longint v, int bits);
		longint hi = (longint'(1) << (bits - 1)) - 1;
		return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
	endfunction

	function automatic longint sine_of(longint phase);
		longint q, x, x2, t, s, v;
		phase = phase & 'hFFFF;
		q = phase >> 14;
		x = (phase & 'h3FFF) << 2;
		if (q & 1) x = 65536 - x;
		x2 = (x * x) >> 16;
		t = 42121 - ((4739 * x2) >> 16);
		t = 102919 - ((t * x2) >> 16);
		s = (t * x) >> 16;
		v = (s * 32767 + 32768) >> 16;
		if (v > 32767) v = 32767;
		return (q & 2) ? -v : v;
	endfunction

	// one PI step with trapezoid integrator and back-calculated anti-windup
	function automatic longint pi_step(int lp, longint err, longint kp, longint ki,
			longint lim, output bit hit);
		longint p, eki, u, o;
		p = (kp * err) >>> 8;
		eki = sat(err - windup[lp], 18);
		integ[lp] = sat(integ[lp] + ki * (eki + prev_err[lp]), 32);
		u = p + (integ[lp] >>> 16);
		hit = 1'b1;
		if (u >= lim) o = lim;
		else if (u <= -lim) o = -lim;
		else begin
			o = u;
			hit = 1'b0;
		end
		windup[lp] = sat(u - o, 32);
		prev_err[lp] = eki;
		return o;
	endfunction

	function automatic foc_result_t predict_tick(logic [95:0] d, logic al);
		longint ia, ib, ang, wr, sref, bus, c, s, k, ph, idr, iqr, vmax, vd, vq;
		bit     sl, dl, ql;
		foc_result_t r;
		ia = longint'($signed(d[15:0]));
		ib = longint'($signed(d[31:16]));
		ang = al ? 0 : longint'(d[47:32]);
		wr = longint'($signed(d[63:48]));
		sref = longint'($signed(d[79:64]));
		bus = longint'(d[95:80]);
		k = (ang * DEPTH) >> 16;
		ph = (k * 65536) / DEPTH;
		s = sine_of(ph);
		c = sine_of(ph + 16384);
		r.i_d = 16'(sat((c * ia + s * ib) >>> 15, 16));
		r.i_q = 16'(sat((c * ib - s * ia) >>> 15, 16));
		if (al) begin
			idr = align_cur;
			iqr = 0;
		end else begin
			idr = 0;
			iqr = pi_step(int'(LP_SPD), sat((spd_scale * sref) >>> 8, 16) - wr,
				kp_spd, ki_spd, iq_lim, sl);
		end
		vmax = (VS_COEF * bus) >>> 16;
		vd = pi_step(int'(LP_D), idr - longint'(r.i_d), kp_cur, ki_cur, vmax, dl);
		vq = pi_step(int'(LP_Q), iqr - longint'(r.i_q), kp_cur, ki_cur, 2 * vmax, ql);
		r.v_alpha = 16'(sat((c * vd - s * vq) >>> 15, 16));
		r.v_beta = 16'(sat((s * vd + c * vq) >>> 15, 16));
		r.iq_cmd = iqr[15:0];
		r.d_lim = dl;
		r.q_lim = ql;
		return r;
	endfunction

	// leaves cfg_valid high; the caller lowers it after the last write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_KP_CURRENT:  kp_cur = val;
			CFG_KI_CURRENT:  ki_cur = val;
			CFG_KP_SPEED:    kp_spd = val;
			CFG_KI_SPEED:    ki_spd = val;
			CFG_IQ_LIMIT:    iq_lim = val[14:0];
			CFG_SPEED_SCALE: spd_scale = val;
			CFG_ALIGN_CUR:   align_cur = longint'($signed(val));
			default: ;
		endcase
		@(negedge clk);
	endtask

	// holds valid across back-to-back transfers; lowered only on an idle gap
	task automatic send_tick(logic [95:0] d, logic al);
		while (!quiet_sender && $urandom_range(99) < 19) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata <= d;
		s_tuser <= al;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		board.note_input(predict_tick(d, al));
		@(negedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	function automatic logic [95:0] pack_tick(logic [15:0] ia, ib, ang, wr, sref, bus);
		return {bus, sref, wr, ang, ib, ia};
	endfunction

	function automatic logic [95:0] rand_tick();
		logic [95:0] d;
		for (int i = 0; i < 3; i++) d[i*32 +: 32] = $urandom();
		// mostly moderate currents and speeds so loops stay off the rails
		if ($urandom_range(3) != 0) begin
			d[15:0] = 16'($signed($urandom_range(8000)) - 4000);
			d[31:16] = 16'($signed($urandom_range(8000)) - 4000);
			d[63:48] = 16'($signed($urandom_range(4000)) - 2000);
			d[79:64] = 16'($signed($urandom_range(4000)) - 2000);
		end
		return d;
	endfunction

	// sink: random stalls, sampled at the rising edge
	always @(negedge clk)
		m_tready <= quiet_sink ? 1'b1 : ($urandom_range(99) >= 19);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result('{$signed(m_tdata[15:0]), $signed(m_tdata[31:16]),
				$signed(m_tdata[47:32]), $signed(m_tdata[63:48]),
				$signed(m_tdata[79:64]), m_tuser[0], m_tuser[1]});
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		logic [15:0] ex[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
		foreach (integ[i]) begin
			integ[i] = 0;
			prev_err[i] = 0;
			windup[i] = 0;
		end
		kp_cur = 256; ki_cur = 0; kp_spd = 256; ki_spd = 0;
		iq_lim = 16384; spd_scale = 256; align_cur = -16384;
		quiet_sender = 1'b0;
		quiet_sink = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: field extremes, both modes, zero bus voltage forces clamps
		for (int i = 0; i < 16; i++)
			send_tick(pack_tick(ex[i % 4], ex[(i / 4) % 4], ex[(i + 1) % 4],
				ex[(i + 2) % 4], ex[(i / 2) % 4], ex[(i + 3) % 4]), i[0]);
		send_tick(pack_tick(16'd1000, 16'd0, 16'h4000, 16'd0, 16'd0, 16'd0), 1'b0);
		send_tick(pack_tick(16'd1000, 16'd0, 16'h3FF, 16'd0, 16'd0, 16'd20000), 1'b1);
		// pause until everything is back
		drain();

		// phases across register settings, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_KP_CURRENT, 16'd512);
					write_reg(CFG_KI_CURRENT, 16'd2000);
					write_reg(CFG_KP_SPEED, 16'd128);
					write_reg(CFG_KI_SPEED, 16'd1500);
				end
				1: begin
					write_reg(CFG_KP_CURRENT, 16'hFFFF);
					write_reg(CFG_KI_CURRENT, 16'hFFFF);
					write_reg(CFG_IQ_LIMIT, 16'hFFFF);
					write_reg(CFG_SPEED_SCALE, 16'hFFFF);
					write_reg(CFG_ALIGN_CUR, 16'h7FFF);
				end
				2: begin
					write_reg(CFG_KP_CURRENT, 16'd0);
					write_reg(CFG_KI_SPEED, 16'hFFFF);
					write_reg(CFG_KP_SPEED, 16'hFFFF);
					write_reg(CFG_IQ_LIMIT, 16'd0);
					write_reg(CFG_SPEED_SCALE, 16'd0);
					write_reg(CFG_ALIGN_CUR, 16'h8000);
				end
				3: begin
					write_reg(CFG_KI_CURRENT, 16'd0);
					write_reg(CFG_KP_SPEED, 16'd0);
					write_reg(CFG_IQ_LIMIT, 16'd3000);
					write_reg(3'd7, 16'h1234);
				end
				default: begin
					for (int r = 0; r < 7; r++)
						write_reg(CFG_IDX_W'(r), 16'($urandom()));
					write_reg(CFG_KI_CURRENT, 16'($urandom_range(3000)));
					write_reg(CFG_KI_SPEED, 16'($urandom_range(3000)));
				end
			endcase
			cfg_valid <= 1'b0;
			quiet_sender = (ph == 2);
			quiet_sink = (ph == 2);
			for (int n = 0; n < 66; n++)
				send_tick(rand_tick(), $urandom_range(9) == 0);
			drain();
		end

		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pfoc_pkg.sv
rtl/pfoc_datapath.sv
rtl/pfoc_ctrl.sv
rtl/pmsm_field_oriented_current_speed_ctrl_unit.sv
test/pmsm_field_oriented_current_speed_ctrl_unit_test.sv
